/* rtl/sqlx_pkg.sv */
// Shared types, token codes, character codes and keyword table of the SQL token lexer.
package sqlx_pkg;

  // Default sizes
  localparam int KwMaxLenDefault  = 8;
  localparam int OffsetWidthDef   = 32;
  localparam int LengthWidthDef   = 16;
  localparam int MaxResults       = 3;
  localparam int NumKeywords      = 33;
  localparam int KwLongest        = 8;
  localparam int QueueDepth       = 4;

  // Scan modes, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE   = 9'b000000001,
    MODE_LT     = 9'b000000010,
    MODE_GT     = 9'b000000100,
    MODE_BANG   = 9'b000001000,
    MODE_STR    = 9'b000010000,
    MODE_INT    = 9'b000100000,
    MODE_INTDOT = 9'b001000000,
    MODE_FRAC   = 9'b010000000,
    MODE_WORD   = 9'b100000000
  } mode_e;

  // Token codes beyond the keywords
  localparam logic [5:0] TOK_LPAREN  = 6'd33;
  localparam logic [5:0] TOK_RPAREN  = 6'd34;
  localparam logic [5:0] TOK_COMMA   = 6'd35;
  localparam logic [5:0] TOK_SEMI    = 6'd36;
  localparam logic [5:0] TOK_STAR    = 6'd37;
  localparam logic [5:0] TOK_DOT     = 6'd38;
  localparam logic [5:0] TOK_EQ      = 6'd39;
  localparam logic [5:0] TOK_LT      = 6'd40;
  localparam logic [5:0] TOK_LE      = 6'd41;
  localparam logic [5:0] TOK_GT      = 6'd42;
  localparam logic [5:0] TOK_GE      = 6'd43;
  localparam logic [5:0] TOK_NE      = 6'd44;
  localparam logic [5:0] TOK_STRING  = 6'd45;
  localparam logic [5:0] TOK_INT     = 6'd46;
  localparam logic [5:0] TOK_FLOAT   = 6'd47;
  localparam logic [5:0] TOK_IDENT   = 6'd48;
  localparam logic [5:0] TOK_UNKNOWN = 6'd49;
  localparam logic [5:0] TOK_END     = 6'd50;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  // One result item
  typedef struct packed {
    logic [5:0]  token_type;
    logic [31:0] text_start;
    logic [15:0] text_length;
    logic [31:0] line_number;
    logic        run_last;
  } token_t;

  // Keyword table, right-aligned text, first character in the top used byte
  localparam logic [63:0] KW_WORD [NumKeywords] = '{
    64'("create"), 64'("table"), 64'("insert"), 64'("into"), 64'("values"),
    64'("select"), 64'("from"), 64'("where"), 64'("update"), 64'("set"),
    64'("delete"), 64'("drop"), 64'("index"), 64'("on"), 64'("begin"),
    64'("commit"), 64'("rollback"), 64'("join"), 64'("inner"), 64'("left"),
    64'("group"), 64'("by"), 64'("order"), 64'("asc"), 64'("desc"),
    64'("count"), 64'("sum"), 64'("avg"), 64'("min"), 64'("max"),
    64'("int"), 64'("float"), 64'("text")
  };
  localparam int KW_LEN [NumKeywords] = '{
    6, 5, 6, 4, 6, 6, 4, 5, 6, 3, 6, 4, 5, 2, 5, 6, 8, 4, 5, 4, 5, 2, 5,
    3, 4, 5, 3, 3, 3, 3, 3, 5, 4
  };

  // Character i of keyword k
  function automatic logic [7:0] kw_char(int k, int i);
    logic [63:0] w;
    w = KW_WORD[k] << (8 * (KwLongest - KW_LEN[k]));
    return w[63 - 8 * i -: 8];
  endfunction

endpackage

/* rtl/sqlx_if.sv */
// Valid/ready channel interfaces for source bytes and tokens.
interface sqlx_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;
  modport source (output valid, output func, output char_code, input ready);
  modport sink (input valid, input func, input char_code, output ready);
endinterface

interface sqlx_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_type;
  logic [31:0] text_start;
  logic [15:0] text_length;
  logic [31:0] line_number;
  logic        run_last;
  modport source (output valid, output token_type, output text_start, output text_length,
                  output line_number, output run_last, input ready);
  modport sink (input valid, input token_type, input text_start, input text_length,
                input line_number, input run_last, output ready);
endinterface

/* rtl/sqlx_scan.sv */
// Scanner state and the per-byte token logic: up to three tokens per transfer.
module sqlx_scan #(
  parameter int KeywordMaxLen = sqlx_pkg::KwMaxLenDefault,
  parameter int OffsetWidth   = sqlx_pkg::OffsetWidthDef,
  parameter int LengthWidth   = sqlx_pkg::LengthWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              func_i,
  input  logic [7:0]        char_i,
  output sqlx_pkg::token_t  tok_o [sqlx_pkg::MaxResults],
  output logic [1:0]        count_o
);
  import sqlx_pkg::*;

  localparam int IdxW = $clog2(KeywordMaxLen);

  mode_e                  mode_q, mode_d;
  logic [OffsetWidth-1:0] start_q, start_d;
  logic [LengthWidth-1:0] len_q, len_d;
  logic [OffsetWidth-1:0] off_q, off_d;
  logic [31:0]            line_q, line_d;
  logic [7:0]             word_q [KeywordMaxLen];

  logic                   wr_en;
  logic [IdxW-1:0]        wr_idx;
  logic [7:0]             wr_char;
  logic [5:0]             word_type;
  token_t                 tok [MaxResults];
  logic [1:0]             n;
  logic                   flush_en, idle_en;

  function automatic logic [LengthWidth-1:0] len_inc(logic [LengthWidth-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
  endfunction

  function automatic token_t mk_tok(logic [5:0] ty, logic [OffsetWidth-1:0] st,
                                    logic [LengthWidth-1:0] ln, logic [31:0] line);
    token_t     t;
    logic [63:0] st_w;
    logic [31:0] ln_w;
    st_w          = 64'(st);
    ln_w          = 32'(ln);
    t.token_type  = ty;
    t.text_start  = st_w[31:0];
    t.text_length = ln_w[15:0];
    t.line_number = line;
    t.run_last    = 1'b0;
    return t;
  endfunction

  // Keyword match against the stored word, all entries in parallel
  always_comb begin
    logic m;
    word_type = TOK_IDENT;
    for (int k = 0; k < NumKeywords; k++) begin
      m = (32'(len_q) == KW_LEN[k]);
      for (int i = 0; i < KwLongest; i++) begin
        if (i < KW_LEN[k]) m = m & (word_q[i] == kw_char(k, i));
      end
      if (m) word_type = 6'(k);
    end
  end

  // Next state and emitted tokens
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    len_d    = len_q;
    off_d    = off_q + 1'b1;
    line_d   = line_q;
    wr_en    = 1'b0;
    wr_idx   = len_q[IdxW-1:0];
    wr_char  = lower(char_i);
    n        = 2'd0;
    flush_en = 1'b0;
    idle_en  = 1'b0;
    for (int r = 0; r < MaxResults; r++) tok[r] = '0;

    if (func_i) begin
      flush_en = 1'b1;
    end else begin
      unique case (mode_q)
        MODE_LT, MODE_GT, MODE_BANG: begin
          if (char_i == CH_EQ) begin
            tok[n] = mk_tok((mode_q == MODE_LT) ? TOK_LE :
                            (mode_q == MODE_GT) ? TOK_GE : TOK_NE,
                            start_q, LengthWidth'(2), line_q);
            n = n + 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        MODE_STR: begin
          if (char_i == CH_QUOTE) begin
            tok[n] = mk_tok(TOK_STRING, start_q, len_q, line_q);
            n = n + 1'b1;
            mode_d = MODE_IDLE;
          end else begin
            len_d = len_inc(len_q);
            if (char_i == CH_LF && !(&line_q)) line_d = line_q + 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(char_i)) len_d = len_inc(len_q);
          else if (char_i == CH_DOT) mode_d = MODE_INTDOT;
          else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        MODE_INTDOT: begin
          if (is_digit(char_i)) begin
            len_d  = len_inc(len_inc(len_q));
            mode_d = MODE_FRAC;
          end else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(char_i)) len_d = len_inc(len_q);
          else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_alpha(char_i) || is_digit(char_i) || char_i == CH_UNDER) begin
            wr_en = (32'(len_q) < 32'(KeywordMaxLen));
            len_d = len_inc(len_q);
          end else begin
            flush_en = 1'b1;
            idle_en  = 1'b1;
          end
        end
        default: idle_en = 1'b1;
      endcase
    end

    // Pending token of the current mode
    if (flush_en) begin
      mode_d = MODE_IDLE;
      unique case (mode_q)
        MODE_LT: begin
          tok[n] = mk_tok(TOK_LT, start_q, LengthWidth'(1), line_q); n = n + 1'b1;
        end
        MODE_GT: begin
          tok[n] = mk_tok(TOK_GT, start_q, LengthWidth'(1), line_q); n = n + 1'b1;
        end
        MODE_BANG: begin
          tok[n] = mk_tok(TOK_UNKNOWN, start_q, LengthWidth'(1), line_q); n = n + 1'b1;
        end
        MODE_STR: begin
          tok[n] = mk_tok(TOK_UNKNOWN, start_q, len_q, line_q); n = n + 1'b1;
        end
        MODE_INT: begin
          tok[n] = mk_tok(TOK_INT, start_q, len_q, line_q); n = n + 1'b1;
        end
        MODE_INTDOT: begin
          tok[n] = mk_tok(TOK_INT, start_q, len_q, line_q); n = n + 1'b1;
          tok[n] = mk_tok(TOK_DOT, off_q - 1'b1, LengthWidth'(1), line_q); n = n + 1'b1;
        end
        MODE_FRAC: begin
          tok[n] = mk_tok(TOK_FLOAT, start_q, len_q, line_q); n = n + 1'b1;
        end
        MODE_WORD: begin
          tok[n] = mk_tok(word_type, start_q, len_q, line_q); n = n + 1'b1;
        end
        default: ;
      endcase
    end

    // Current byte seen from idle
    if (idle_en) begin
      mode_d = MODE_IDLE;
      case (char_i)
        CH_SPACE, CH_TAB, CH_CR: ;
        CH_LF:     if (!(&line_q)) line_d = line_q + 1'b1;
        CH_LPAREN: begin tok[n] = mk_tok(TOK_LPAREN, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_RPAREN: begin tok[n] = mk_tok(TOK_RPAREN, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_COMMA:  begin tok[n] = mk_tok(TOK_COMMA, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_SEMI:   begin tok[n] = mk_tok(TOK_SEMI, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_STAR:   begin tok[n] = mk_tok(TOK_STAR, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_DOT:    begin tok[n] = mk_tok(TOK_DOT, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_EQ:     begin tok[n] = mk_tok(TOK_EQ, off_q, LengthWidth'(1), line_q); n = n + 1'b1; end
        CH_LT:     begin mode_d = MODE_LT; start_d = off_q; end
        CH_GT:     begin mode_d = MODE_GT; start_d = off_q; end
        CH_BANG:   begin mode_d = MODE_BANG; start_d = off_q; end
        CH_QUOTE: begin
          mode_d  = MODE_STR;
          start_d = off_q + 1'b1;
          len_d   = '0;
        end
        default: begin
          if (is_digit(char_i)) begin
            mode_d  = MODE_INT;
            start_d = off_q;
            len_d   = LengthWidth'(1);
          end else if (is_alpha(char_i) || char_i == CH_UNDER) begin
            mode_d  = MODE_WORD;
            start_d = off_q;
            len_d   = LengthWidth'(1);
            wr_en   = 1'b1;
            wr_idx  = '0;
          end else begin
            tok[n] = mk_tok(TOK_UNKNOWN, off_q, LengthWidth'(1), line_q);
            n = n + 1'b1;
          end
        end
      endcase
    end

    // End marker: end token, then back to reset state
    if (func_i) begin
      tok[n] = mk_tok(TOK_END, off_q, '0, line_q);
      n = n + 1'b1;
      mode_d  = MODE_IDLE;
      start_d = '0;
      len_d   = '0;
      off_d   = '0;
      line_d  = 32'd1;
      wr_en   = 1'b0;
    end

    if (n != 2'd0) tok[n - 1'b1].run_last = 1'b1;
  end

  assign tok_o   = tok;
  assign count_o = n;

  // Scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      len_q   <= '0;
      off_q   <= '0;
      line_q  <= 32'd1;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      off_q   <= off_d;
      line_q  <= line_d;
    end
  end

  // Lowercased word store
  always_ff @(posedge clk_i) begin
    if (fire_i && wr_en) word_q[wr_idx] <= wr_char;
  end

endmodule

/* rtl/sqlx_queue.sv */
// Four-slot result queue: takes up to three tokens at once, hands out one per transfer.
module sqlx_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sqlx_pkg::token_t  push_tok_i [sqlx_pkg::MaxResults],
  input  logic [1:0]        push_cnt_i,
  input  logic              pop_i,
  output logic              space_o,
  output logic              valid_o,
  output sqlx_pkg::token_t  tok_o
);
  import sqlx_pkg::*;

  token_t     slot_q [QueueDepth];
  token_t     slot_d [QueueDepth];
  logic [2:0] cnt_q, cnt_d;
  logic [2:0] base;
  logic [2:0] add;

  // Room for a full set of three after this cycle's transfer
  assign space_o = (cnt_q <= 3'd1) || (cnt_q == 3'd2 && pop_i);
  assign valid_o = (cnt_q != 3'd0);
  assign tok_o   = slot_q[0];

  // Shift out on pop, then append new tokens behind the survivors
  always_comb begin
    logic [2:0] rel;
    base = cnt_q - {2'b0, pop_i};
    add  = push_i ? {1'b0, push_cnt_i} : 3'd0;
    for (int j = 0; j < QueueDepth; j++) begin
      rel = 3'(j) - base;
      if (3'(j) < base) begin
        if (pop_i && j < QueueDepth - 1) slot_d[j] = slot_q[j + 1];
        else slot_d[j] = slot_q[j];
      end else if (rel < add) begin
        slot_d[j] = push_tok_i[rel[1:0]];
      end else begin
        slot_d[j] = slot_q[j];
      end
    end
    cnt_d = base + add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

/* rtl/sql_token_lexer.sv */
// Streaming SQL lexer: one source byte (or end marker) per transfer in, tokens out.
// Each accepted byte is scanned in the same cycle it is taken and yields zero to three
// tokens, which go into a four-slot queue; the output side hands out one token per
// cycle while the receiver is ready. The input takes one byte per cycle as long as the
// queue has room for three more tokens, so the sustained rate is one byte per cycle
// until the stream yields more than one token per byte; the single output port then sets
// the pace. Token text is not copied: a token carries its start offset, length and
// the line count at the moment it was emitted. An end marker flushes any open token,
// emits the end token with run_last set, and returns the scanner to its reset state.
module sql_token_lexer #(
  parameter int KeywordMaxLen = sqlx_pkg::KwMaxLenDefault,
  parameter int OffsetWidth   = sqlx_pkg::OffsetWidthDef,
  parameter int LengthWidth   = sqlx_pkg::LengthWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqlx_in_if.sink    in_i,
  sqlx_out_if.source out_o
);
  import sqlx_pkg::*;

  token_t     scan_tok [MaxResults];
  logic [1:0] scan_cnt;
  token_t     head_tok;
  logic       space;
  logic       in_fire;
  logic       out_fire;

  assign in_i.ready = space;
  assign in_fire    = in_i.valid && space;
  assign out_fire   = out_o.valid && out_o.ready;

  // Scanner
  sqlx_scan #(
    .KeywordMaxLen(KeywordMaxLen),
    .OffsetWidth  (OffsetWidth),
    .LengthWidth  (LengthWidth)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .func_i (in_i.func),
    .char_i (in_i.char_code),
    .tok_o  (scan_tok),
    .count_o(scan_cnt)
  );

  // Result queue
  sqlx_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_fire),
    .push_tok_i(scan_tok),
    .push_cnt_i(scan_cnt),
    .pop_i     (out_fire),
    .space_o   (space),
    .valid_o   (out_o.valid),
    .tok_o     (head_tok)
  );

  assign out_o.token_type  = head_tok.token_type;
  assign out_o.text_start  = head_tok.text_start;
  assign out_o.text_length = head_tok.text_length;
  assign out_o.line_number = head_tok.line_number;
  assign out_o.run_last    = head_tok.run_last;

endmodule

/* tb/tb_sql_token_lexer.sv */
// Testbench for the streaming SQL lexer: scoreboard against a behavioral token predictor.
`timescale 1ns / 100ps

module tb_sql_token_lexer;
  import sqlx_pkg::*;

  typedef enum int {
    SC_IDLE, SC_LT, SC_GT, SC_BANG, SC_STR, SC_INT, SC_INTDOT, SC_FRAC, SC_WORD
  } scan_e;

  typedef struct packed {
    logic       func;
    logic [7:0] char_code;
  } src_item_t;

  logic clk_i;
  logic rst_ni;

  sqlx_in_if  in_ch ();
  sqlx_out_if out_ch ();

  sql_token_lexer i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Keyword text for the predictor
  string kw_names [NumKeywords] = '{
    "create", "table", "insert", "into", "values", "select", "from", "where",
    "update", "set", "delete", "drop", "index", "on", "begin", "commit",
    "rollback", "join", "inner", "left", "group", "by", "order", "asc",
    "desc", "count", "sum", "avg", "min", "max", "int", "float", "text"
  };

  src_item_t pending_src[$];
  token_t    token_expect[$];
  int        mismatch_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        src_taken;

  // Predictor state
  scan_e       lx_mode;
  logic [7:0]  lx_word [KwMaxLenDefault];
  logic [31:0] lx_start;
  logic [15:0] lx_len;
  logic [31:0] lx_offset;
  logic [31:0] lx_line;
  token_t      step_toks[$];

  function automatic void lx_reset();
    lx_mode   = SC_IDLE;
    lx_start  = '0;
    lx_len    = '0;
    lx_offset = '0;
    lx_line   = 32'd1;
  endfunction

  function automatic void put_tok(logic [5:0] ty, logic [31:0] st, logic [15:0] ln);
    token_t t;
    t.token_type  = ty;
    t.text_start  = st;
    t.text_length = ln;
    t.line_number = lx_line;
    t.run_last    = 1'b0;
    if (step_toks.size() < MaxResults) step_toks.push_back(t);
  endfunction

  function automatic logic [15:0] len_sat(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [5:0] classify_word();
    bit same;
    if (lx_len > KwMaxLenDefault) return TOK_IDENT;
    for (int k = 0; k < NumKeywords; k++) begin
      same = (kw_names[k].len() == lx_len);
      for (int i = 0; i < kw_names[k].len() && same; i++)
        if (kw_names[k][i] != lx_word[i]) same = 0;
      if (same) return 6'(k);
    end
    return TOK_IDENT;
  endfunction

  function automatic void line_up();
    if (lx_line != 32'hFFFF_FFFF) lx_line++;
  endfunction

  // Byte seen with no token open
  function automatic void scan_fresh(logic [7:0] c);
    lx_mode = SC_IDLE;
    case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF:     line_up();
      CH_LPAREN: put_tok(TOK_LPAREN, lx_offset, 16'd1);
      CH_RPAREN: put_tok(TOK_RPAREN, lx_offset, 16'd1);
      CH_COMMA:  put_tok(TOK_COMMA, lx_offset, 16'd1);
      CH_SEMI:   put_tok(TOK_SEMI, lx_offset, 16'd1);
      CH_STAR:   put_tok(TOK_STAR, lx_offset, 16'd1);
      CH_DOT:    put_tok(TOK_DOT, lx_offset, 16'd1);
      CH_EQ:     put_tok(TOK_EQ, lx_offset, 16'd1);
      CH_LT:     begin lx_mode = SC_LT; lx_start = lx_offset; end
      CH_GT:     begin lx_mode = SC_GT; lx_start = lx_offset; end
      CH_BANG:   begin lx_mode = SC_BANG; lx_start = lx_offset; end
      CH_QUOTE:  begin lx_mode = SC_STR; lx_start = lx_offset + 32'd1; lx_len = '0; end
      default: begin
        if (is_dig(c)) begin
          lx_mode = SC_INT; lx_start = lx_offset; lx_len = 16'd1;
        end else if (is_let(c) || c == CH_UNDER) begin
          lx_mode = SC_WORD; lx_start = lx_offset; lx_len = 16'd1;
          lx_word[0] = to_lower(c);
        end else begin
          put_tok(TOK_UNKNOWN, lx_offset, 16'd1);
        end
      end
    endcase
  endfunction

  // Close whatever token is open
  function automatic void close_open();
    case (lx_mode)
      SC_LT:   put_tok(TOK_LT, lx_start, 16'd1);
      SC_GT:   put_tok(TOK_GT, lx_start, 16'd1);
      SC_BANG: put_tok(TOK_UNKNOWN, lx_start, 16'd1);
      SC_STR:  put_tok(TOK_UNKNOWN, lx_start, lx_len);
      SC_INT:  put_tok(TOK_INT, lx_start, lx_len);
      SC_INTDOT: begin
        put_tok(TOK_INT, lx_start, lx_len);
        put_tok(TOK_DOT, lx_offset - 32'd1, 16'd1);
      end
      SC_FRAC: put_tok(TOK_FLOAT, lx_start, lx_len);
      SC_WORD: put_tok(classify_word(), lx_start, lx_len);
      default: ;
    endcase
    lx_mode = SC_IDLE;
  endfunction

  // Expected tokens for one source item, appended to token_expect
  function automatic void predict_tokens(src_item_t it);
    logic [7:0] c;
    c = it.char_code;
    step_toks.delete();
    if (it.func) begin
      close_open();
      put_tok(TOK_END, lx_offset, 16'd0);
      lx_reset();
    end else begin
      case (lx_mode)
        SC_LT, SC_GT, SC_BANG: begin
          if (c == CH_EQ) begin
            put_tok(lx_mode == SC_LT ? TOK_LE : lx_mode == SC_GT ? TOK_GE : TOK_NE,
                    lx_start, 16'd2);
            lx_mode = SC_IDLE;
          end else begin
            close_open(); scan_fresh(c);
          end
        end
        SC_STR: begin
          if (c == CH_QUOTE) begin
            put_tok(TOK_STRING, lx_start, lx_len);
            lx_mode = SC_IDLE;
          end else begin
            lx_len = len_sat(lx_len);
            if (c == CH_LF) line_up();
          end
        end
        SC_INT: begin
          if (is_dig(c)) lx_len = len_sat(lx_len);
          else if (c == CH_DOT) lx_mode = SC_INTDOT;
          else begin close_open(); scan_fresh(c); end
        end
        SC_INTDOT: begin
          if (is_dig(c)) begin
            lx_len = len_sat(len_sat(lx_len));
            lx_mode = SC_FRAC;
          end else begin
            close_open(); scan_fresh(c);
          end
        end
        SC_FRAC: begin
          if (is_dig(c)) lx_len = len_sat(lx_len);
          else begin close_open(); scan_fresh(c); end
        end
        SC_WORD: begin
          if (is_let(c) || is_dig(c) || c == CH_UNDER) begin
            if (lx_len < KwMaxLenDefault) lx_word[lx_len[2:0]] = to_lower(c);
            lx_len = len_sat(lx_len);
          end else begin
            close_open(); scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
      lx_offset++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].run_last = 1'b1;
    foreach (step_toks[i]) token_expect.push_back(step_toks[i]);
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // Stimulus helpers
  task automatic push_text(string s);
    src_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.func = 1'b0;
      it.char_code = s[i];
      pending_src.push_back(it);
    end
  endtask

  task automatic push_end();
    src_item_t it;
    it.func = 1'b1;
    it.char_code = 8'($urandom);
    pending_src.push_back(it);
  endtask

  function automatic string random_fragment();
    string pieces [16] = '{
      "SELECT ", "from ", "WhErE ", "rollback ", "identifier_long ", "x1 ",
      "'str' ", "12.5 ", "7. ", "<=", ">= ", "!=", "<", "(a,b);", "*", "\n"
    };
    return pieces[$urandom_range(0, 15)];
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Driver: updates at the falling edge, holds an offered item until its transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !src_taken) begin
      in_ch.valid <= 1'b1;
    end else if (pending_src.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      in_ch.valid     <= 1'b1;
      in_ch.func      <= pending_src[0].func;
      in_ch.char_code <= pending_src[0].char_code;
    end else begin
      in_ch.valid <= 1'b0;
    end
    src_taken = 1'b0;
  end

  // Receiver stall
  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: samples at the rising edge
  always @(posedge clk_i) begin
    token_t got;
    token_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.token_type, out_ch.text_start, out_ch.text_length,
              out_ch.line_number, out_ch.run_last};
      if (token_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected token type %0d", got.token_type));
      end else begin
        want = token_expect.pop_front();
        if (got.token_type != want.token_type)
          report_mismatch($sformatf("type %0d want %0d", got.token_type, want.token_type));
        if (got.text_start != want.text_start)
          report_mismatch($sformatf("start %0d want %0d", got.text_start, want.text_start));
        if (got.text_length != want.text_length)
          report_mismatch($sformatf("length %0d want %0d", got.text_length,
                                    want.text_length));
        if (got.line_number != want.line_number)
          report_mismatch($sformatf("line %0d want %0d", got.line_number, want.line_number));
        if (got.run_last != want.run_last)
          report_mismatch($sformatf("run_last %0b want %0b", got.run_last, want.run_last));
      end
    end
    // Input transfer at this edge feeds the predictor
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      predict_tokens(src_item_t'({in_ch.func, in_ch.char_code}));
      void'(pending_src.pop_front());
      src_taken = 1'b1;
    end
  end

  // Hard stop
  initial begin
    #2ms;
    $display("** sql_token_lexer: FAILED **");
    $finish;
  end

  // Main sequence
  initial begin
    src_item_t it;
    mismatch_cnt    = 0;
    src_taken       = 1'b0;
    send_idle_pct   = 18;
    recv_idle_pct   = 57;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = 1'b0;
    in_ch.char_code = 8'h00;
    out_ch.ready    = 1'b0;
    lx_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: keywords, operators, strings, dot rule, unknowns, end handling
    push_text("CREATE table(x,y);*.=<a<=b>c>=d!e!=f");
    push_end();
    push_text("'it\ns' 12.5 7.x 3. rollbacks Text _id9 ");
    it.func = 1'b0; it.char_code = 8'hFF; pending_src.push_back(it);
    it.char_code = 8'h00; pending_src.push_back(it);
    push_text("9.");
    push_end();
    push_text("'open");
    push_end();
    push_text("<");
    push_end();
    push_end();

    // Random: mostly well-formed SQL fragments, some raw bytes
    for (int n = 0; n < 70; ) begin
      if ($urandom_range(0, 3) == 0) begin
        it.func = 1'b0;
        it.char_code = 8'($urandom);
        pending_src.push_back(it);
        n++;
      end else begin
        string s;
        s = random_fragment();
        push_text(s);
        n += s.len();
      end
      if ($urandom_range(0, 29) == 0) push_end();
      if (n > 20 && send_idle_pct == 18) begin
        wait (pending_src.size() == 0);
        send_idle_pct = 57; recv_idle_pct = 18;
      end else if (n > 45 && send_idle_pct == 57) begin
        wait (pending_src.size() == 0);
        send_idle_pct = 0; recv_idle_pct = 0;
      end
    end
    push_end();

    wait (pending_src.size() == 0);
    @(negedge clk_i);
    wait (token_expect.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && token_expect.size() == 0) begin
      $display("** sql_token_lexer: PASSED **");
    end else begin
      $display("** sql_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sqlx_pkg.sv
rtl/sqlx_if.sv
rtl/sqlx_scan.sv
rtl/sqlx_queue.sv
rtl/sql_token_lexer.sv
tb/tb_sql_token_lexer.sv
